FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros: concurrent assertion helpers
// clocked assertions with asynchronous active-low reset disable
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

FILE: hw/rtl/hpbp_pkg.sv
// ----------------------------------------------------------------------------
// hpbp_pkg
// shared constants and types of the half-pel block predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hpbp_pkg;

	localparam int HPBP_MAX_BLOCK = 16;
	localparam int SAMPLE_W       = 16;

	// latched half-pel mode, bit 0 horizontal, bit 1 vertical
	localparam logic [1:0] MODE_FULL = 2'b00;
	localparam logic [1:0] MODE_H    = 2'b01;
	localparam logic [1:0] MODE_V    = 2'b10;
	localparam logic [1:0] MODE_HV   = 2'b11;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		logic       emit;
		logic       last;
		logic [1:0] mode;
	} hpbp_ctl_t;

endpackage

FILE: hw/rtl/hpbp_cell.sv
// ----------------------------------------------------------------------------
// hpbp_cell
// one stage of the line delay chain, holds a sample and passes it on
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpbp_cell (
	input  logic             clk,
	input  logic             shift_en,
	input  hpbp_pkg::sample_t d,
	output hpbp_pkg::sample_t q
);
	import hpbp_pkg::*;

	sample_t data_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			data_q <= d;
		end
	end

	assign q = data_q;

endmodule

FILE: hw/rtl/hpbp_filter.sv
// ----------------------------------------------------------------------------
// hpbp_filter
// half-pel averaging and the output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hpbp_filter (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_fire,
	input  hpbp_pkg::hpbp_ctl_t ctl,
	input  hpbp_pkg::sample_t   cur,
	input  hpbp_pkg::sample_t   left,
	input  hpbp_pkg::sample_t   upper,
	input  hpbp_pkg::sample_t   upper_left,
	input  logic                out_ready,
	output logic                out_valid,
	output hpbp_pkg::sample_t   out_sample,
	output logic                out_last
);
	import hpbp_pkg::*;

	logic signed [SAMPLE_W+1:0] sum4;
	logic signed [SAMPLE_W:0]   sum_h;
	logic signed [SAMPLE_W:0]   sum_v;
	logic signed [SAMPLE_W+1:0] avg4;
	logic signed [SAMPLE_W:0]   avg_h;
	logic signed [SAMPLE_W:0]   avg_v;
	sample_t                    pred;
	logic                       valid_q;
	sample_t                    sample_q;
	logic                       last_q;

	always_comb begin
		sum4  = (SAMPLE_W+2)'(upper_left) + (SAMPLE_W+2)'(upper)
			+ (SAMPLE_W+2)'(left) + (SAMPLE_W+2)'(cur);
		sum_h = (SAMPLE_W+1)'(left) + (SAMPLE_W+1)'(cur);
		sum_v = (SAMPLE_W+1)'(upper) + (SAMPLE_W+1)'(cur);
		avg4  = sum4 >>> 2;
		avg_h = sum_h >>> 1;
		avg_v = sum_v >>> 1;
		case (ctl.mode)
			MODE_FULL: pred = cur;
			MODE_H:    pred = avg_h[SAMPLE_W-1:0];
			MODE_V:    pred = avg_v[SAMPLE_W-1:0];
			MODE_HV:   pred = avg4[SAMPLE_W-1:0];
			default:   pred = cur;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_fire) begin
			valid_q <= ctl.emit;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && ctl.emit) begin
			sample_q <= pred;
			last_q   <= ctl.last;
		end
	end

	assign out_valid  = valid_q;
	assign out_sample = sample_q;
	assign out_last   = last_q;

endmodule

FILE: hw/rtl/half_pel_block_predictor_unit.sv
// ----------------------------------------------------------------------------
// half_pel_block_predictor_unit
// half-pel motion compensation of one block from a raster reference window
// ----------------------------------------------------------------------------
// channel  | dir | payload
// s_axis   | in  | tdata: sample; tuser: half_right, half_down
// m_axis   | out | tdata: pred_sample; tlast: last
// cfg      | in  | cfg_wr_data: chroma_mode
//
// one transaction per clock in while s_axis_tready is high, at most one per clock out
// the averaging stage is combinational and its result is held in the output register
// the line delay is a chain of MAX_BLOCK+1 cells shifting on each input
// s_axis_tready is high while the output register is empty or being taken
// reset clears counters, mode and output valid; the cell chain is not reset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module half_pel_block_predictor_unit #(
	parameter int MAX_BLOCK = hpbp_pkg::HPBP_MAX_BLOCK
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [15:0] sample
	input  logic [1:0]  s_axis_tuser,   // [0] half_right, [1] half_down
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [15:0] pred_sample
	output logic        m_axis_tlast,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data
);
	import hpbp_pkg::*;

	localparam int CW    = $clog2(MAX_BLOCK + 2);
	localparam int DEPTH = MAX_BLOCK + 1;
	localparam logic [CW-1:0] BLK_LUMA   = CW'(MAX_BLOCK);
	localparam logic [CW-1:0] BLK_CHROMA = CW'(MAX_BLOCK / 2);

	logic          chroma_q;
	logic [CW-1:0] row_q;
	logic [CW-1:0] col_q;
	logic [1:0]    mode_q;
	sample_t       upper_left_q;

	logic          in_fire;
	logic          first;
	logic [1:0]    mode_eff;
	logic [CW-1:0] blk;
	logic [CW-1:0] width;
	logic [CW-1:0] height;
	logic          row_end;
	logic          win_end;
	sample_t       cur;
	sample_t       upper;
	sample_t       chain [DEPTH+1];
	hpbp_ctl_t     ctl;
	logic          out_valid;
	sample_t       out_sample;

	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = !out_valid || m_axis_tready;
	assign cur           = sample_t'(s_axis_tdata);

	always_comb begin
		first    = (row_q == '0) && (col_q == '0);
		mode_eff = first ? {s_axis_tuser[1], s_axis_tuser[0]} : mode_q;
		blk      = chroma_q ? BLK_CHROMA : BLK_LUMA;
		width    = blk + CW'(mode_eff[0]);
		height   = blk + CW'(mode_eff[1]);
		row_end  = (col_q == width - CW'(1));
		win_end  = row_end && (row_q == height - CW'(1));
		upper    = chain[width];
		ctl.mode = mode_eff;
		ctl.last = win_end;
		case (mode_eff)
			MODE_FULL: ctl.emit = 1'b1;
			MODE_H:    ctl.emit = (col_q != '0);
			MODE_V:    ctl.emit = (row_q != '0);
			MODE_HV:   ctl.emit = (col_q != '0) && (row_q != '0);
			default:   ctl.emit = 1'b1;
		endcase
	end

	// chain[0] is the incoming sample, chain[k] the sample k transactions back
	assign chain[0] = cur;

	for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
		hpbp_cell u_cell (
			.clk      (clk),
			.shift_en (in_fire),
			.d        (chain[gi]),
			.q        (chain[gi+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chroma_q <= 1'b0;
			row_q    <= '0;
			col_q    <= '0;
			mode_q   <= MODE_FULL;
		end else if (cfg_wr_en) begin
			chroma_q <= cfg_wr_data;
			row_q    <= '0;
			col_q    <= '0;
		end else if (in_fire) begin
			mode_q <= mode_eff;
			if (row_end) begin
				col_q <= '0;
				row_q <= win_end ? '0 : row_q + CW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			upper_left_q <= upper;
		end
	end

	hpbp_filter u_filter (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_fire    (in_fire),
		.ctl        (ctl),
		.cur        (cur),
		.left       (chain[1]),
		.upper      (upper),
		.upper_left (upper_left_q),
		.out_ready  (m_axis_tready),
		.out_valid  (out_valid),
		.out_sample (out_sample),
		.out_last   (m_axis_tlast)
	);

	assign m_axis_tvalid = out_valid;
	assign m_axis_tdata  = out_sample;

	`ASSERT_NEVER(a_col_range, clk, arst_n, col_q > CW'(MAX_BLOCK), "column counter out of range")
	`ASSERT_NEVER(a_row_range, clk, arst_n, row_q > CW'(MAX_BLOCK), "row counter out of range")
	`ASSERT_CLK(a_full_emits, clk, arst_n, in_fire && (mode_eff == MODE_FULL) |=> m_axis_tvalid, "full-pel transaction gave no result")
	`ASSERT_CLK(a_first_silent, clk, arst_n, in_fire && first && (mode_eff != MODE_FULL) |=> !m_axis_tvalid, "first window sample gave a result in half-pel mode")

endmodule
